[rtl/grid_cell_range_enumerator_core_assert.svh]
// Assertion helpers for the grid cell enumerator.
// Both sample on the rising edge of clock and stay quiet while reset is high.
`ifndef GRID_CELL_RANGE_ENUMERATOR_CORE_ASSERT_SVH
`define GRID_CELL_RANGE_ENUMERATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define GCRE_ASSERT_NOW(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication.
`define GCRE_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

[rtl/gcre_pkg.sv]
`default_nettype none

package gcre_pkg;

   localparam int MAX_CELLS   = 64;
   localparam int CELL_CNT_W  = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int COORD_W     = 24;
   localparam int CFG_W       = 16;
   localparam int SIZE_W      = 13;
   localparam int INDEX_W     = 32;
   localparam int DIVIDEND_W  = 17;
   localparam int DIV_CNT_W   = $clog2(DIVIDEND_W + 1);
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ORIGIN_X,
      CSR_ORIGIN_Y,
      CSR_EXTENT_X,
      CSR_EXTENT_Y,
      CSR_CELL_SIZE
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] rect_left;
      logic signed [COORD_W-1:0] rect_top;
      logic [COORD_W-1:0]        rect_span_x;
      logic [COORD_W-1:0]        rect_span_y;
   } req_payload_type;

   typedef struct packed {
      logic [INDEX_W-1:0] cell_index;
      logic               no_cells;
      logic               truncated;
      logic               last_cell;
   } rsp_payload_type;

   // divider command and status
   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [SIZE_W-1:0]     divisor;
   } div_ctl_type;

   typedef struct packed {
      logic                  busy;
      logic [DIVIDEND_W-1:0] quotient;
   } div_stat_type;

   // microcode
   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_CLAMP,
      OP_OFFSET,
      OP_DIV_START,
      OP_DIV_STORE,
      OP_MUL,
      OP_INIT,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      SEL_COLS,
      SEL_MIN_X,
      SEL_MIN_Y,
      SEL_MAX_X,
      SEL_MAX_Y
   } sel_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_REQ,
      STALL_DIV,
      STALL_RSP
   } stall_type;

   typedef enum logic [1:0] {
      BR_NEVER,
      BR_ALWAYS,
      BR_EMPTY,
      BR_MORE
   } branch_type;

   localparam int PROG_LEN = 17;
   localparam int STEP_W   = $clog2(PROG_LEN);

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_ACCEPT     = STEP_W'(0);
   localparam step_type STEP_CLAMP      = STEP_W'(1);
   localparam step_type STEP_OFFSET     = STEP_W'(2);
   localparam step_type STEP_COLS       = STEP_W'(3);
   localparam step_type STEP_COLS_WAIT  = STEP_W'(4);
   localparam step_type STEP_MINX       = STEP_W'(5);
   localparam step_type STEP_MINX_WAIT  = STEP_W'(6);
   localparam step_type STEP_MINY       = STEP_W'(7);
   localparam step_type STEP_MINY_WAIT  = STEP_W'(8);
   localparam step_type STEP_MAXX       = STEP_W'(9);
   localparam step_type STEP_MAXX_WAIT  = STEP_W'(10);
   localparam step_type STEP_MAXY       = STEP_W'(11);
   localparam step_type STEP_MAXY_WAIT  = STEP_W'(12);
   localparam step_type STEP_MUL        = STEP_W'(13);
   localparam step_type STEP_INIT       = STEP_W'(14);
   localparam step_type STEP_EMIT       = STEP_W'(15);
   localparam step_type STEP_DONE       = STEP_W'(16);

   typedef struct packed {
      op_type     op;
      sel_type    sel;
      stall_type  stall;
      branch_type branch;
      step_type   target;
   } ctl_word_type;

   function automatic ctl_word_type make_word(input op_type op, input sel_type sel,
                                              input stall_type stall,
                                              input branch_type branch,
                                              input step_type target);
      ctl_word_type w;
      w.op     = op;
      w.sel    = sel;
      w.stall  = stall;
      w.branch = branch;
      w.target = target;
      return w;
   endfunction

   // control store
   function automatic ctl_word_type microcode(input step_type step);
      ctl_word_type w;
      case (step)
         STEP_ACCEPT:    w = make_word(OP_ACCEPT, SEL_COLS, STALL_REQ, BR_NEVER, STEP_ACCEPT);
         STEP_CLAMP:     w = make_word(OP_CLAMP, SEL_COLS, STALL_NONE, BR_NEVER, STEP_ACCEPT);
         STEP_OFFSET:    w = make_word(OP_OFFSET, SEL_COLS, STALL_NONE, BR_EMPTY, STEP_EMIT);
         STEP_COLS:      w = make_word(OP_DIV_START, SEL_COLS, STALL_NONE, BR_NEVER,
                                       STEP_ACCEPT);
         STEP_COLS_WAIT: w = make_word(OP_DIV_STORE, SEL_COLS, STALL_DIV, BR_NEVER,
                                       STEP_ACCEPT);
         STEP_MINX:      w = make_word(OP_DIV_START, SEL_MIN_X, STALL_NONE, BR_NEVER,
                                       STEP_ACCEPT);
         STEP_MINX_WAIT: w = make_word(OP_DIV_STORE, SEL_MIN_X, STALL_DIV, BR_NEVER,
                                       STEP_ACCEPT);
         STEP_MINY:      w = make_word(OP_DIV_START, SEL_MIN_Y, STALL_NONE, BR_NEVER,
                                       STEP_ACCEPT);
         STEP_MINY_WAIT: w = make_word(OP_DIV_STORE, SEL_MIN_Y, STALL_DIV, BR_NEVER,
                                       STEP_ACCEPT);
         STEP_MAXX:      w = make_word(OP_DIV_START, SEL_MAX_X, STALL_NONE, BR_NEVER,
                                       STEP_ACCEPT);
         STEP_MAXX_WAIT: w = make_word(OP_DIV_STORE, SEL_MAX_X, STALL_DIV, BR_NEVER,
                                       STEP_ACCEPT);
         STEP_MAXY:      w = make_word(OP_DIV_START, SEL_MAX_Y, STALL_NONE, BR_NEVER,
                                       STEP_ACCEPT);
         STEP_MAXY_WAIT: w = make_word(OP_DIV_STORE, SEL_MAX_Y, STALL_DIV, BR_NEVER,
                                       STEP_ACCEPT);
         STEP_MUL:       w = make_word(OP_MUL, SEL_COLS, STALL_NONE, BR_NEVER, STEP_ACCEPT);
         STEP_INIT:      w = make_word(OP_INIT, SEL_COLS, STALL_NONE, BR_NEVER, STEP_ACCEPT);
         STEP_EMIT:      w = make_word(OP_EMIT, SEL_COLS, STALL_RSP, BR_MORE, STEP_EMIT);
         STEP_DONE:      w = make_word(OP_NOP, SEL_COLS, STALL_NONE, BR_ALWAYS, STEP_ACCEPT);
         default:        w = make_word(OP_NOP, SEL_COLS, STALL_NONE, BR_ALWAYS, STEP_ACCEPT);
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

[rtl/gcre_req_if.sv]
`default_nettype none

interface gcre_req_if import gcre_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/gcre_rsp_if.sv]
`default_nettype none

interface gcre_rsp_if import gcre_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/gcre_divider.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module gcre_divider import gcre_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire div_ctl_type ctl,
   output div_stat_type stat
);

   logic                  busy_ff, busy_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SIZE_W-1:0]     rem_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [SIZE_W-1:0]     dvs_ff;

   logic [SIZE_W:0] shifted;
   logic [SIZE_W:0] diff;
   logic            fits;

   assign shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits    = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIVIDEND_W);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         rem_ff <= '0;
         quo_ff <= ctl.dividend;
         dvs_ff <= ctl.divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[SIZE_W-1:0] : shifted[SIZE_W-1:0];
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], fits};
      end
   end

   assign stat.busy     = busy_ff;
   assign stat.quotient = quo_ff;

endmodule

`default_nettype wire

[rtl/grid_cell_range_enumerator_core.sv]
`default_nettype none
`include "grid_cell_range_enumerator_core_assert.svh"

// Channel  | Dir | Handshake             | Carries
// ---------+-----+-----------------------+-------------------------------------------
// req_ch   | in  | valid/ready, sink     | rect_left, rect_top, rect_span_x/_y (16.8)
// rsp_ch   | out | valid/ready, source   | cell_index, no_cells, truncated, last_cell
// csr_*    | in  | write enable only     | world origin/extent, cell size
//
// One request at a time. A request that misses the world branches from the
// offset step straight to the emit step for its single response. Otherwise
// it emits N cells (N up to MAX_CELLS) after five passes through the shared
// bit-serial divider. Reset is synchronous and active high; it loads the
// register defaults and returns the sequencer to the accept step. A stalled
// response holds the sequencer on the emit step with all payload stable.
module grid_cell_range_enumerator_core import gcre_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   gcre_req_if.sink                    req_ch,
   gcre_rsp_if.source                  rsp_ch,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]       csr_write_data
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic signed [CFG_W-1:0] origin_x_ff;
   logic signed [CFG_W-1:0] origin_y_ff;
   logic [CFG_W-1:0]        extent_x_ff;
   logic [CFG_W-1:0]        extent_y_ff;
   logic [SIZE_W-1:0]       cell_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         extent_x_ff  <= CFG_W'(1024);
         extent_y_ff  <= CFG_W'(1024);
         cell_size_ff <= SIZE_W'(64);
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_ORIGIN_X:  origin_x_ff  <= csr_write_data;
            CSR_ORIGIN_Y:  origin_y_ff  <= csr_write_data;
            CSR_EXTENT_X:  extent_x_ff  <= csr_write_data;
            CSR_EXTENT_Y:  extent_y_ff  <= csr_write_data;
            CSR_CELL_SIZE: cell_size_ff <= csr_write_data[SIZE_W-1:0];
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   // a zero cell size acts as one
   logic [SIZE_W-1:0] grid;
   assign grid = (cell_size_ff == '0) ? SIZE_W'(1) : cell_size_ff;

   // ---------------------------------------------------------------
   // Sequencer: step counter plus control store
   // ---------------------------------------------------------------
   step_type     pc_ff, pc_in;
   ctl_word_type word;
   logic         stalled;
   logic         taken;
   logic         req_fire;
   logic         rsp_fire;
   logic         empty_now;
   logic         out_last;

   div_ctl_type  div_ctl;
   div_stat_type div_stat;

   assign word = microcode(pc_ff);

   assign req_ch.ready = (word.op == OP_ACCEPT);
   assign rsp_ch.valid = (word.op == OP_EMIT);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign rsp_fire     = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      case (word.stall)
         STALL_REQ: stalled = !req_ch.valid;
         STALL_DIV: stalled = div_stat.busy;
         STALL_RSP: stalled = !rsp_ch.ready;
         default:   stalled = 1'b0;
      endcase
      case (word.branch)
         BR_ALWAYS: taken = 1'b1;
         BR_EMPTY:  taken = empty_now;
         BR_MORE:   taken = !out_last;
         default:   taken = 1'b0;
      endcase
      // hold on a stall, jump on a taken branch, otherwise advance
      if (stalled) begin
         pc_in = pc_ff;
      end else if (taken) begin
         pc_in = word.target;
      end else begin
         pc_in = pc_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_ACCEPT;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // ---------------------------------------------------------------
   // Datapath
   // ---------------------------------------------------------------
   // corners in whole units, floored start and ceiled end, then clamped
   logic signed [CFG_W+1:0] x0_ff, x1_ff, y0_ff, y1_ff;
   logic [CFG_W-1:0]        lo_x_ff, hi_x_ff, lo_y_ff, hi_y_ff;
   logic                    empty_ff;
   logic [CFG_W-1:0]        cols_ff, min_x_ff, min_y_ff, max_x_ff, max_y_ff;
   logic [INDEX_W-1:0]      prod_ff;
   logic [INDEX_W-1:0]      row_start_ff;
   logic [INDEX_W-1:0]      index_ff;
   logic [CFG_W-1:0]        x_ff, y_ff;
   logic [CELL_CNT_W-1:0]   n_ff;

   // floor and ceil of the incoming corners
   logic signed [COORD_W+1:0] end_x_sum, end_y_sum;
   assign end_x_sum = $signed({{2{req_ch.payload.rect_left[COORD_W-1]}},
                               req_ch.payload.rect_left})
                      + $signed({2'b00, req_ch.payload.rect_span_x})
                      + $signed((COORD_W+2)'(255));
   assign end_y_sum = $signed({{2{req_ch.payload.rect_top[COORD_W-1]}},
                               req_ch.payload.rect_top})
                      + $signed({2'b00, req_ch.payload.rect_span_y})
                      + $signed((COORD_W+2)'(255));

   // world bounds, widened so that origin plus extent cannot wrap
   logic signed [CFG_W+1:0] org_x, org_y, end_x, end_y;
   assign org_x = $signed({{2{origin_x_ff[CFG_W-1]}}, origin_x_ff});
   assign org_y = $signed({{2{origin_y_ff[CFG_W-1]}}, origin_y_ff});
   assign end_x = org_x + $signed({2'b00, extent_x_ff});
   assign end_y = org_y + $signed({2'b00, extent_y_ff});

   assign empty_now = (x1_ff <= x0_ff) || (y1_ff <= y0_ff);

   logic signed [CFG_W+1:0] rel_x0, rel_x1, rel_y0, rel_y1;
   assign rel_x0 = x0_ff - org_x;
   assign rel_y0 = y0_ff - org_y;
   assign rel_x1 = x1_ff - org_x - $signed((CFG_W+2)'(1));
   assign rel_y1 = y1_ff - org_y - $signed((CFG_W+2)'(1));

   // divider operand select
   always_comb begin
      div_ctl.start   = (word.op == OP_DIV_START);
      div_ctl.divisor = grid;
      case (word.sel)
         SEL_COLS:  div_ctl.dividend = DIVIDEND_W'(extent_x_ff) + DIVIDEND_W'(grid)
                                       - DIVIDEND_W'(1);
         SEL_MIN_X: div_ctl.dividend = DIVIDEND_W'(lo_x_ff);
         SEL_MIN_Y: div_ctl.dividend = DIVIDEND_W'(lo_y_ff);
         SEL_MAX_X: div_ctl.dividend = DIVIDEND_W'(hi_x_ff);
         SEL_MAX_Y: div_ctl.dividend = DIVIDEND_W'(hi_y_ff);
         default:   div_ctl.dividend = '0;
      endcase
   end

   gcre_divider u_divider (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .stat  (div_stat)
   );

   logic [INDEX_W-1:0] prod_wide;
   logic [INDEX_W-1:0] next_row;
   logic               at_row_end;
   logic               at_final;
   logic               at_limit;

   assign prod_wide  = INDEX_W'(min_y_ff) * INDEX_W'(cols_ff);
   assign next_row   = row_start_ff + INDEX_W'(cols_ff);
   assign at_row_end = (x_ff == max_x_ff);
   assign at_final   = at_row_end && (y_ff == max_y_ff);
   assign at_limit   = (n_ff == CELL_CNT_W'(MAX_CELLS - 1));
   assign out_last   = empty_ff || at_final || at_limit;

   always_ff @(posedge clock) begin
      case (word.op)
         OP_ACCEPT: begin
            // capture every cycle; the value taken at the handshake is what stays
            x0_ff <= $signed({{2{req_ch.payload.rect_left[COORD_W-1]}},
                              req_ch.payload.rect_left[COORD_W-1:8]});
            y0_ff <= $signed({{2{req_ch.payload.rect_top[COORD_W-1]}},
                              req_ch.payload.rect_top[COORD_W-1:8]});
            x1_ff <= end_x_sum[COORD_W+1:8];
            y1_ff <= end_y_sum[COORD_W+1:8];
         end
         OP_CLAMP: begin
            x0_ff <= (x0_ff < org_x) ? org_x : x0_ff;
            y0_ff <= (y0_ff < org_y) ? org_y : y0_ff;
            x1_ff <= (x1_ff > end_x) ? end_x : x1_ff;
            y1_ff <= (y1_ff > end_y) ? end_y : y1_ff;
         end
         OP_OFFSET: begin
            // offsets are in range only when the box is not empty
            empty_ff <= empty_now;
            lo_x_ff  <= rel_x0[CFG_W-1:0];
            lo_y_ff  <= rel_y0[CFG_W-1:0];
            hi_x_ff  <= rel_x1[CFG_W-1:0];
            hi_y_ff  <= rel_y1[CFG_W-1:0];
         end
         OP_DIV_STORE: begin
            if (!div_stat.busy) begin
               case (word.sel)
                  SEL_COLS:  cols_ff  <= div_stat.quotient[CFG_W-1:0];
                  SEL_MIN_X: min_x_ff <= div_stat.quotient[CFG_W-1:0];
                  SEL_MIN_Y: min_y_ff <= div_stat.quotient[CFG_W-1:0];
                  SEL_MAX_X: max_x_ff <= div_stat.quotient[CFG_W-1:0];
                  SEL_MAX_Y: max_y_ff <= div_stat.quotient[CFG_W-1:0];
                  default: begin
                  end
               endcase
            end
         end
         OP_MUL: begin
            prod_ff <= prod_wide;
         end
         OP_INIT: begin
            row_start_ff <= prod_ff + INDEX_W'(min_x_ff);
            index_ff     <= prod_ff + INDEX_W'(min_x_ff);
            x_ff         <= min_x_ff;
            y_ff         <= min_y_ff;
            n_ff         <= '0;
         end
         OP_EMIT: begin
            // advance in row-major order once the response is taken
            if (rsp_fire && !out_last) begin
               n_ff <= n_ff + CELL_CNT_W'(1);
               if (at_row_end) begin
                  x_ff         <= min_x_ff;
                  y_ff         <= y_ff + CFG_W'(1);
                  row_start_ff <= next_row;
                  index_ff     <= next_row;
               end else begin
                  x_ff     <= x_ff + CFG_W'(1);
                  index_ff <= index_ff + INDEX_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // response payload straight from the cell registers
   assign rsp_ch.payload.cell_index = empty_ff ? '0 : index_ff;
   assign rsp_ch.payload.no_cells   = empty_ff;
   assign rsp_ch.payload.truncated  = !empty_ff && at_limit && !at_final;
   assign rsp_ch.payload.last_cell  = out_last;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `GCRE_ASSERT_NOW(a_accept_div_idle, req_ch.ready, !div_stat.busy, "request taken while dividing")
   `GCRE_ASSERT_NOW(a_empty_is_last, rsp_ch.valid && empty_ff, out_last, "empty not final")
   `GCRE_ASSERT_NOW(a_trunc_is_last, rsp_ch.valid && rsp_ch.payload.truncated, at_limit, "bad cut")
   `GCRE_ASSERT_NEXT(a_last_ends, rsp_fire && out_last, !rsp_ch.valid, "response after last")
   `GCRE_ASSERT_NEXT(a_more_follows, rsp_fire && !out_last, rsp_ch.valid, "run ended early")
   `GCRE_ASSERT_NEXT(a_no_overlap, rsp_ch.valid, !req_ch.ready, "request taken mid-run")

endmodule

`default_nettype wire
